// ===== rtl/wus_pkg.sv =====
// Package for the Weierstrass unit scaling block: payload structs, status codes,
// sequencer state and operation enums. Depends on nothing else.
`timescale 1ns / 1ps

package wus_pkg;

	localparam int MOD_BITS_DEF = 31;
	localparam int DATA_W       = 31;
	localparam int STATUS_W     = 2;

	localparam logic [STATUS_W-1:0] ST_NONSINGULAR = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SINGULAR    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_INVERSE  = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] unit_value;
		logic [DATA_W-1:0] coeff_a_in;
		logic [DATA_W-1:0] coeff_b_in;
	} wus_in_t;

	typedef struct packed {
		logic [DATA_W-1:0]   coeff_a_out;
		logic [DATA_W-1:0]   coeff_b_out;
		logic [STATUS_W-1:0] curve_status;
	} wus_out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_POST,
		S_CHECK,
		S_GCDCHK,
		S_DONE
	} wus_state_t;

	typedef enum logic [4:0] {
		OP_RED_U,
		OP_RED_A,
		OP_RED_B,
		OP_EUC_DIV,
		OP_EUC_MUL,
		OP_V2,
		OP_V4,
		OP_A,
		OP_V6,
		OP_B,
		OP_A2,
		OP_A3,
		OP_A3X4,
		OP_B2,
		OP_B2X27,
		OP_DELTA,
		OP_GCD
	} wus_op_t;

endpackage

// ===== rtl/weierstrass_unit_scaling.sv =====
// Top level of the Weierstrass unit scaling block: modulus register, operation
// sequencer and one shared multiply and bit-serial divide unit. Uses wus_pkg.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low. The result then appears
// on result for exactly one cycle with done high, and must be captured in that
// cycle since it cannot be held off. Every operation runs through one shared unit
// that restoring-divides a DW-bit dividend (DW = max(2*max(MOD_BITS,5), 31), 62
// at the default) one bit per cycle. A check state follows each Euclid step and
// each gcd step, and also the input reductions and the discriminant. A command
// takes 3 input reductions, two operations per Euclid step, eleven modular
// multiplications and one operation per gcd step. A unit that is not invertible
// ends the command after the failing Euclid step, and a modulus below two goes
// from idle straight to the done state. The modulus register can be written
// only while the block is idle; cfg_ready is low while a command is in flight.
module weierstrass_unit_scaling
	import wus_pkg::*;
#(
	parameter int MOD_BITS = MOD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  wus_in_t           cmd,
	output logic              done,
	output wus_out_t          result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [DATA_W-1:0] cfg_data
);

	localparam int W  = MOD_BITS;
	localparam int OW = (W > 5) ? W : 5;
	localparam int DW = (2 * OW > DATA_W) ? 2 * OW : DATA_W;
	localparam int CW = $clog2(DW + 1);

	wus_state_t state_q, state_d;
	wus_op_t    op_q;

	logic [DATA_W-1:0] modulus_q;
	logic [W-1:0]      n;
	wus_in_t           in_q;
	wus_out_t          res_q;

	logic [W-1:0] u_q, ca_q, cb_q, r0_q, r1_q, t0_q, t1_q, q_q;
	logic [W-1:0] v2_q, v4_q, a_q, b_q, p_q, e_q;

	// Shared unit registers.
	logic [DW-1:0] dvd_q;
	logic [W-1:0]  dvs_q, rem_q, quo_q;
	logic [CW-1:0] cnt_q;

	logic [DW-1:0]   src_dvd;
	logic [W-1:0]    src_dvs;
	logic            use_mul;
	logic [OW-1:0]   mul_a, mul_b;
	logic [2*OW-1:0] prod;
	logic [W:0]      rem_ext, rem_sub;
	logic            ge;
	logic [W:0]      sum_t, sum_s;
	logic [W-1:0]    qm;

	assign n         = modulus_q[W-1:0];
	assign cfg_ready = ~busy;

	// Modulus register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= DATA_W'(5);
		end else if (cfg_valid && cfg_ready) begin
			modulus_q <= cfg_data;
		end
	end

	// Operand selection for the shared unit.
	always_comb begin
		use_mul = 1'b1;
		mul_a   = '0;
		mul_b   = '0;
		src_dvs = n;
		src_dvd = '0;
		case (op_q)
			OP_RED_U: begin
				use_mul = 1'b0;
				src_dvd = DW'(in_q.unit_value);
			end
			OP_RED_A: begin
				use_mul = 1'b0;
				src_dvd = DW'(in_q.coeff_a_in);
			end
			OP_RED_B: begin
				use_mul = 1'b0;
				src_dvd = DW'(in_q.coeff_b_in);
			end
			OP_EUC_DIV, OP_GCD: begin
				use_mul = 1'b0;
				src_dvd = DW'(r0_q);
				src_dvs = r1_q;
			end
			OP_EUC_MUL: begin
				mul_a = OW'(q_q);
				mul_b = OW'(t1_q);
			end
			OP_V2: begin
				mul_a = OW'(t0_q);
				mul_b = OW'(t0_q);
			end
			OP_V4: begin
				mul_a = OW'(v2_q);
				mul_b = OW'(v2_q);
			end
			OP_A: begin
				mul_a = OW'(ca_q);
				mul_b = OW'(v4_q);
			end
			OP_V6: begin
				mul_a = OW'(v4_q);
				mul_b = OW'(v2_q);
			end
			OP_B: begin
				mul_a = OW'(cb_q);
				mul_b = OW'(p_q);
			end
			OP_A2: begin
				mul_a = OW'(a_q);
				mul_b = OW'(a_q);
			end
			OP_A3: begin
				mul_a = OW'(p_q);
				mul_b = OW'(a_q);
			end
			OP_A3X4: begin
				mul_a = OW'(4);
				mul_b = OW'(p_q);
			end
			OP_B2: begin
				mul_a = OW'(b_q);
				mul_b = OW'(b_q);
			end
			OP_B2X27: begin
				mul_a = OW'(27);
				mul_b = OW'(e_q);
			end
			OP_DELTA: begin
				mul_a = OW'(16);
				mul_b = OW'(e_q);
			end
			default: begin
				use_mul = 1'b0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// One restoring division step.
	assign rem_ext = {rem_q, dvd_q[DW-1]};
	assign rem_sub = rem_ext - {1'b0, dvs_q};
	assign ge      = (rem_ext >= {1'b0, dvs_q});

	// Post-processing helpers: quotient folded below n, and modular add/sub.
	assign qm    = (quo_q >= n) ? (quo_q - n) : quo_q;
	always_comb begin
		sum_t = '0;
		case (op_q)
			OP_EUC_MUL: sum_t = {1'b0, t0_q} + {1'b0, n} - {1'b0, rem_q};
			default:    sum_t = {1'b0, p_q} + {1'b0, rem_q};
		endcase
		sum_s = (sum_t >= {1'b0, n}) ? (sum_t - {1'b0, n}) : sum_t;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (n < W'(2)) ? S_DONE : S_LOAD;
				end
			end
			S_LOAD: state_d = S_DIV;
			S_DIV: begin
				if (cnt_q == CW'(DW - 1)) begin
					state_d = S_POST;
				end
			end
			S_POST: begin
				case (op_q)
					OP_RED_B, OP_EUC_MUL: state_d = S_CHECK;
					OP_DELTA, OP_GCD:     state_d = S_GCDCHK;
					default:              state_d = S_LOAD;
				endcase
			end
			S_CHECK: begin
				if (r1_q == '0 && r0_q != W'(1)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_LOAD;
				end
			end
			S_GCDCHK: begin
				if (r1_q == '0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_LOAD;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_RED_U;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: op_q <= OP_RED_U;
				S_POST: begin
					case (op_q)
						OP_RED_U:   op_q <= OP_RED_A;
						OP_RED_A:   op_q <= OP_RED_B;
						OP_EUC_DIV: op_q <= OP_EUC_MUL;
						OP_V2:      op_q <= OP_V4;
						OP_V4:      op_q <= OP_A;
						OP_A:       op_q <= OP_V6;
						OP_V6:      op_q <= OP_B;
						OP_B:       op_q <= OP_A2;
						OP_A2:      op_q <= OP_A3;
						OP_A3:      op_q <= OP_A3X4;
						OP_A3X4:    op_q <= OP_B2;
						OP_B2:      op_q <= OP_B2X27;
						OP_B2X27:   op_q <= OP_DELTA;
						default:    op_q <= op_q;
					endcase
				end
				S_CHECK:  op_q <= (r1_q == '0) ? OP_V2 : OP_EUC_DIV;
				S_GCDCHK: op_q <= OP_GCD;
				default:  op_q <= op_q;
			endcase
		end
	end

	// Datapath registers and result capture.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				in_q  <= cmd;
				res_q <= '{coeff_a_out: '0, coeff_b_out: '0, curve_status: ST_NO_INVERSE};
			end
			S_LOAD: begin
				dvd_q <= use_mul ? DW'(prod) : src_dvd;
				dvs_q <= src_dvs;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
			end
			S_DIV: begin
				rem_q <= ge ? rem_sub[W-1:0] : rem_ext[W-1:0];
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
				quo_q <= {quo_q[W-2:0], ge};
				cnt_q <= cnt_q + CW'(1);
			end
			S_POST: begin
				case (op_q)
					OP_RED_U: u_q <= rem_q;
					OP_RED_A: ca_q <= rem_q;
					OP_RED_B: begin
						cb_q <= rem_q;
						r0_q <= n;
						r1_q <= u_q;
						t0_q <= '0;
						t1_q <= W'(1);
					end
					OP_EUC_DIV: begin
						q_q  <= qm;
						r0_q <= r1_q;
						r1_q <= rem_q;
					end
					OP_EUC_MUL: begin
						t0_q <= t1_q;
						t1_q <= sum_s[W-1:0];
					end
					OP_V2: v2_q <= rem_q;
					OP_V4: v4_q <= rem_q;
					OP_A:  a_q <= rem_q;
					OP_V6: p_q <= rem_q;
					OP_B:  b_q <= rem_q;
					OP_A2, OP_A3, OP_A3X4: p_q <= rem_q;
					OP_B2: e_q <= rem_q;
					OP_B2X27: e_q <= sum_s[W-1:0];
					OP_DELTA: begin
						r0_q <= (rem_q == '0) ? '0 : (n - rem_q);
						r1_q <= n;
					end
					OP_GCD: begin
						r0_q <= r1_q;
						r1_q <= rem_q;
					end
					default: ;
				endcase
			end
			S_GCDCHK: begin
				if (r1_q == '0) begin
					res_q.coeff_a_out  <= DATA_W'(a_q);
					res_q.coeff_b_out  <= DATA_W'(b_q);
					res_q.curve_status <= (r0_q == W'(1)) ? ST_NONSINGULAR : ST_SINGULAR;
				end
			end
			default: ;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		busy   = (state_q != S_IDLE);
		done   = (state_q == S_DONE);
		result = res_q;
	end

endmodule

// ===== tb/sv/weierstrass_unit_scaling_tb.sv =====
// Testbench for weierstrass_unit_scaling: directed and random commands over many moduli,
// each result checked against a scoreboard fed by a behavioral scaling predictor.
// Depends on wus_pkg and the weierstrass_unit_scaling RTL.
`timescale 1ns / 1ps

module weierstrass_unit_scaling_tb;
	import wus_pkg::*;

	localparam longint CYCLE_LIMIT = 64'd60_000_000;
	localparam int     DRAIN_CYCLES = 200;
	localparam int     EXP_DEPTH = 16;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	wus_in_t  cmd;
	logic     done;
	wus_out_t result;
	logic     cfg_valid;
	logic     cfg_ready;
	logic [DATA_W-1:0] cfg_data;

	// Modulus as the block should hold it, and the ring of predicted curves.
	logic [DATA_W-1:0] cur_modulus;
	wus_out_t          scaled_curves[EXP_DEPTH];
	int                exp_wr;
	int                exp_rd;
	int                mismatch_count;
	longint            cycle_count;
	int                burst_left;

	weierstrass_unit_scaling DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned mul_reduce(longint unsigned x, longint unsigned y,
			longint unsigned n);
		return (x * y) % n;
	endfunction

	function automatic longint unsigned common_divisor(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Scale the curve by the inverse unit and classify its discriminant.
	function automatic wus_out_t scale_curve(wus_in_t c, logic [DATA_W-1:0] modreg);
		wus_out_t o;
		longint unsigned n, u, ca, cb, v, v2, v4, v6, a, b, t, delta;
		longint r0, r1, q, s0, s1, tmp;
		o.coeff_a_out = '0;
		o.coeff_b_out = '0;
		o.curve_status = ST_NO_INVERSE;
		n = modreg;
		if (n < 2)
			return o;
		u = c.unit_value % n;
		ca = c.coeff_a_in % n;
		cb = c.coeff_b_in % n;
		// Extended Euclid tracking the coefficient of u.
		r0 = n;
		r1 = u;
		s0 = 0;
		s1 = 1;
		while (r1 != 0) begin
			q = r0 / r1;
			tmp = r0 - q * r1;
			r0 = r1;
			r1 = tmp;
			tmp = s0 - q * s1;
			s0 = s1;
			s1 = tmp;
		end
		if (r0 != 1)
			return o;
		s0 = s0 % longint'(n);
		if (s0 < 0)
			s0 = s0 + longint'(n);
		v = s0;
		v2 = mul_reduce(v, v, n);
		v4 = mul_reduce(v2, v2, n);
		v6 = mul_reduce(v4, v2, n);
		a = mul_reduce(ca, v4, n);
		b = mul_reduce(cb, v6, n);
		t = (mul_reduce(4 % n, mul_reduce(mul_reduce(a, a, n), a, n), n)
			+ mul_reduce(27 % n, mul_reduce(b, b, n), n)) % n;
		delta = mul_reduce((n - (16 % n)) % n, t, n);
		o.coeff_a_out = DATA_W'(a);
		o.coeff_b_out = DATA_W'(b);
		o.curve_status = (common_divisor(delta, n) == 1) ? ST_NONSINGULAR : ST_SINGULAR;
		return o;
	endfunction

	// Every strobed result is compared against the oldest prediction.
	always @(posedge clk) begin
		wus_out_t exp_curve;
		if (arst_n && done) begin
			if (exp_wr == exp_rd) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result %h", result);
			end else begin
				exp_curve = scaled_curves[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (result.coeff_a_out !== exp_curve.coeff_a_out
						|| result.coeff_b_out !== exp_curve.coeff_b_out
						|| result.curve_status !== exp_curve.curve_status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp a=%0d b=%0d st=%0d got a=%0d b=%0d st=%0d",
							exp_curve.coeff_a_out, exp_curve.coeff_b_out,
							exp_curve.curve_status, result.coeff_a_out,
							result.coeff_b_out, result.curve_status);
				end
			end
		end
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Send one command; the sender idles between bursts of random length.
	task automatic send_cmd(input wus_in_t item);
		cmd <= item;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		scaled_curves[exp_wr % EXP_DEPTH] = scale_curve(item, cur_modulus);
		exp_wr++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 6);
		end
	endtask

	task automatic send_fields(input longint unsigned u, input longint unsigned ca,
			input longint unsigned cb);
		wus_in_t item;
		item.unit_value = DATA_W'(u);
		item.coeff_a_in = DATA_W'(ca);
		item.coeff_b_in = DATA_W'(cb);
		send_cmd(item);
	endtask

	// The modulus is written only once every pending result has arrived.
	task automatic write_modulus(input logic [DATA_W-1:0] value);
		start <= 1'b0;
		while (exp_wr != exp_rd)
			@(posedge clk);
		@(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_modulus = value;
		@(posedge clk);
	endtask

	// Extremes of every field under the reset modulus and degenerate moduli.
	task automatic test_directed();
		send_fields(0, 0, 0);
		send_fields(1, 0, 0);
		send_fields(1, 1, 1);
		send_fields(4, 3, 2);
		send_fields(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
		send_fields(5, 1, 1);
		send_fields(2, 0, 1);
		write_modulus(DATA_W'(0));
		send_fields(3, 2, 1);
		write_modulus(DATA_W'(1));
		send_fields(3, 2, 1);
		write_modulus(DATA_W'(9));
		send_fields(3, 1, 1);
		send_fields(2, 6, 0);
		write_modulus(DATA_W'(4));
		send_fields(3, 1, 2);
		write_modulus(31'h7FFFFFFF);
		send_fields(31'h7FFFFFFE, 31'h7FFFFFFE, 31'h7FFFFFFE);
		send_fields(31'h7FFFFFFF, 5, 5);
		send_fields(31'h55555555, 31'h2AAAAAAA, 31'h55555555);
		send_fields(1, 31'h7FFFFFFC, 2);
		write_modulus(DATA_W'(35));
		send_fields(7, 1, 1);
		send_fields(2, 32, 2);
	endtask

	// Random moduli, mostly small; mostly well formed curves, some singular, some noise.
	task automatic test_random();
		longint unsigned n, u, k, ca, cb;
		logic [DATA_W-1:0] new_mod;
		int pick;
		for (int phase = 0; phase < 21; phase++) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				new_mod = DATA_W'($urandom_range(5, 300));
			else if (pick < 8)
				new_mod = DATA_W'($urandom_range(1000, 1 << 20));
			else if (pick < 9)
				new_mod = DATA_W'($urandom & 32'h7FFFFFFF);
			else
				new_mod = DATA_W'(32'h7FFFFFFF - $urandom_range(0, 64));
			write_modulus(new_mod);
			n = (new_mod < 2) ? 2 : new_mod;
			for (int i = 0; i < 50; i++) begin
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					send_fields($urandom & 32'h7FFFFFFF, $urandom & 32'h7FFFFFFF,
						$urandom & 32'h7FFFFFFF);
				end else begin
					u = $urandom_range(1, n - 1);
					if (pick < 4) begin
						// 4a^3 + 27b^2 vanishes for a = -3k^2, b = 2k^3.
						k = $urandom_range(0, n - 1);
						ca = (n - mul_reduce(3, mul_reduce(k, k, n), n)) % n;
						cb = mul_reduce(2, mul_reduce(mul_reduce(k, k, n), k, n), n);
					end else begin
						ca = $urandom_range(0, n - 1);
						cb = $urandom_range(0, n - 1);
					end
					send_fields(u, ca, cb);
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		cur_modulus = DATA_W'(5);
		exp_wr = 0;
		exp_rd = 0;
		mismatch_count = 0;
		cycle_count = 0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		start <= 1'b0;
		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
